// ===== hw/rtl/ddp_pkg.sv =====
// Shared types, constants and the multiply program for the pose step unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ddp_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;

    localparam int AXLE_BITS  = 31;
    localparam int DT_BITS    = 17;
    localparam int ANG_BITS   = 32;
    localparam int CFG_BITS   = 31;
    localparam int CFG_IDX_BITS = 1;
    localparam int SUM_BITS   = WORD_BITS + 1;
    localparam int NUM_BITS   = SUM_BITS + DT_BITS;
    localparam int TURN_SHIFT = 61 - FRAC_BITS;
    localparam int DVD_BITS   = NUM_BITS + TURN_SHIFT;
    localparam int DCNT_BITS  = $clog2(DVD_BITS + 1);
    localparam int CV_BITS    = 34;
    localparam int CCNT_BITS  = $clog2(CORDIC_STEPS + 1);
    localparam int PC_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AXLE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DT   = 1'b1;

    localparam logic [AXLE_BITS-1:0] AXLE_RESET = 31'd65536;
    localparam logic [DT_BITS-1:0]   DT_RESET   = 17'd655;

    localparam logic [32:0] TWOPI_Q29 = 33'd3373259426;
    localparam logic signed [CV_BITS-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CV_BITS-1:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [CV_BITS-1:0] HALF     = 34'sd2147483648;
    localparam logic signed [63:0] WIDE_LIM = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] POS_MAX  = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_MIN  = -(64'sd1 <<< (WORD_BITS - 1));

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CORD_STEP, OP_CORD_SAVE_H, OP_NUM, OP_DEN, OP_DIV_STEP,
        OP_TURN, OP_DIST, OP_RNUM, OP_RSAVE, OP_CORD_SAVE_T, OP_MQ_PREP, OP_MQ_LO,
        OP_MQ_HI, OP_MQ_FIN, OP_UPDATE
    } t_op;

    typedef enum logic [1:0] {A_DIST, A_R, A_RS, A_RC} t_asel;
    typedef enum logic [1:0] {B_CH, B_SH, B_CA, B_SA} t_bsel;
    typedef enum logic [2:0] {D_RS, D_RC, D_XADD, D_YADD, D_YSUB} t_dst;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_dst  dst;
        logic  last;
    } t_prog_ent;

    typedef struct packed {
        t_op   op;
        t_asel asel;
        t_bsel bsel;
        t_dst  dst;
    } t_cmd;

    typedef struct packed {
        logic cord_done;
        logic div_done;
        logic turn_zero;
        logic out_busy;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_CORD_H, S_NUM, S_DEN, S_DIVT, S_BRANCH, S_DIVR, S_CORD_T,
        S_MQ_PREP, S_MQ_LO, S_MQ_HI, S_MQ_FIN, S_UPD
    } t_state;

    localparam logic [PC_BITS-1:0] PC_CURVED   = 3'd0;
    localparam logic [PC_BITS-1:0] PC_STRAIGHT = 3'd6;

    // curved: rs, rc, then the four rotation terms; straight: two terms
    function automatic t_prog_ent prog_entry(input logic [PC_BITS-1:0] pc);
        t_prog_ent e;
        case (pc)
            3'd0: e = '{asel: A_R,    bsel: B_SH, dst: D_RS,   last: 1'b0};
            3'd1: e = '{asel: A_R,    bsel: B_CH, dst: D_RC,   last: 1'b0};
            3'd2: e = '{asel: A_RS,   bsel: B_CA, dst: D_XADD, last: 1'b0};
            3'd3: e = '{asel: A_RC,   bsel: B_SA, dst: D_XADD, last: 1'b0};
            3'd4: e = '{asel: A_RS,   bsel: B_SA, dst: D_YADD, last: 1'b0};
            3'd5: e = '{asel: A_RC,   bsel: B_CA, dst: D_YSUB, last: 1'b1};
            3'd6: e = '{asel: A_DIST, bsel: B_CH, dst: D_XADD, last: 1'b0};
            default: e = '{asel: A_DIST, bsel: B_SH, dst: D_YADD, last: 1'b1};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ddp_if.sv =====
// Valid/ready channels for wheel-speed input words and pose output words.
// Depends on ddp_pkg for field widths.
`default_nettype none
interface ddp_in_if import ddp_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] left_speed;
    logic signed [WORD_BITS-1:0] right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

interface ddp_out_if import ddp_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] pose_x;
    logic signed [WORD_BITS-1:0] pose_y;
    logic        [ANG_BITS-1:0]  heading;

    modport source (output valid, output pose_x, output pose_y, output heading, input ready);
    modport sink (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/diff_drive_pose_step_unit.sv =====
// Differential-drive pose step unit: integrates wheel speeds into x, y, heading.
// Depends on ddp_pkg, ddp_if, ddp_ctrl and ddp_datapath.
//
// Use: each input word on i_in carries left and right wheel speeds (Q16.16)
// for one tick. The unit advances its stored pose and emits one output word
// on o_out with the saturated position and the wrapped binary-angle heading.
// Configuration (axle length, time step) is written through i_cfg_* by the
// user only while idle; the block itself does not enforce it.
// One word at a time: a straight step runs a 24-step CORDIC on the heading,
// a 95-step bit-serial turn-angle division and two Q30 products; a curved
// step adds a 64-step radius division, a second 24-step CORDIC and four
// more products.
// i_in.ready is high only while the sequencer is idle.
// Reset clears the pose to zero and loads the default axle length and step.
// The result sits in an output register; a new word is accepted while it
// waits, and the next result is held back until o_out.ready takes the last.
`default_nettype none
module diff_drive_pose_step_unit import ddp_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    ddp_in_if.sink                       i_in,
    ddp_out_if.source                    o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    ddp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ddp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_left_speed  (i_in.left_speed),
        .i_right_speed (i_in.right_speed),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pose_x      (o_out.pose_x),
        .o_pose_y      (o_out.pose_y),
        .o_heading     (o_out.heading)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ddp_ctrl.sv =====
// Sequencer for the pose step: walks CORDIC, divider and multiply phases.
// Depends on ddp_pkg; drives the datapath through t_cmd, reads t_stat.
`default_nettype none
module ddp_ctrl import ddp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic [PC_BITS-1:0] r_pc, n_pc;
    t_prog_ent w_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_CURVED;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        w_ent       = prog_entry(r_pc);
        o_cmd.op    = OP_NONE;
        o_cmd.asel  = w_ent.asel;
        o_cmd.bsel  = w_ent.bsel;
        o_cmd.dst   = w_ent.dst;
        o_in_ready  = 1'b0;
        n_state     = r_state;
        n_pc        = r_pc;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CORD_H;
                end
            end
            S_CORD_H: begin
                if (i_stat.cord_done) begin
                    o_cmd.op = OP_CORD_SAVE_H;
                    n_state  = S_NUM;
                end else begin
                    o_cmd.op = OP_CORD_STEP;
                end
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_DEN;
            end
            S_DEN: begin
                o_cmd.op = OP_DEN;
                n_state  = S_DIVT;
            end
            S_DIVT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_TURN;
                    n_state  = S_BRANCH;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            S_BRANCH: begin
                if (i_stat.turn_zero) begin
                    o_cmd.op = OP_DIST;
                    n_pc     = PC_STRAIGHT;
                    n_state  = S_MQ_PREP;
                end else begin
                    o_cmd.op = OP_RNUM;
                    n_state  = S_DIVR;
                end
            end
            S_DIVR: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_RSAVE;
                    n_state  = S_CORD_T;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            S_CORD_T: begin
                if (i_stat.cord_done) begin
                    o_cmd.op = OP_CORD_SAVE_T;
                    n_pc     = PC_CURVED;
                    n_state  = S_MQ_PREP;
                end else begin
                    o_cmd.op = OP_CORD_STEP;
                end
            end
            S_MQ_PREP: begin
                o_cmd.op = OP_MQ_PREP;
                n_state  = S_MQ_LO;
            end
            S_MQ_LO: begin
                o_cmd.op = OP_MQ_LO;
                n_state  = S_MQ_HI;
            end
            S_MQ_HI: begin
                o_cmd.op = OP_MQ_HI;
                n_state  = S_MQ_FIN;
            end
            S_MQ_FIN: begin
                o_cmd.op = OP_MQ_FIN;
                if (w_ent.last) begin
                    n_state = S_UPD;
                end else begin
                    n_pc    = r_pc + 3'd1;
                    n_state = S_MQ_PREP;
                end
            end
            S_UPD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_UPDATE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ddp_datapath.sv =====
// Pose state, config registers, shared multiplier, bit-serial divider,
// iterative CORDIC and output register. Depends on ddp_pkg; run by ddp_ctrl.
`default_nettype none
module ddp_datapath import ddp_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    output t_stat                            o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]         i_cfg_data,
    input  wire logic signed [WORD_BITS-1:0] i_left_speed,
    input  wire logic signed [WORD_BITS-1:0] i_right_speed,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic signed [WORD_BITS-1:0]      o_pose_x,
    output logic signed [WORD_BITS-1:0]      o_pose_y,
    output logic [ANG_BITS-1:0]              o_heading
);

    logic [AXLE_BITS-1:0] r_axle;
    logic [DT_BITS-1:0]   r_dt;
    logic signed [WORD_BITS-1:0] r_px, r_py;
    logic [ANG_BITS-1:0] r_hd, r_turn;

    logic signed [SUM_BITS-1:0] r_sum, r_diff;
    logic [SUM_BITS-1:0] r_abs_sum, r_abs_diff;
    logic [NUM_BITS-1:0] r_num;

    logic [DVD_BITS-1:0]  r_dvd;
    logic [63:0]          r_dvs, r_rem, r_quo;
    logic [DCNT_BITS-1:0] r_dcnt;

    logic signed [CV_BITS-1:0] r_cx, r_cy, r_cz, r_ch, r_sh, r_ca, r_sa;
    logic                      r_flip;
    logic [CCNT_BITS-1:0]      r_ccnt;

    logic signed [63:0] r_dist, r_r, r_rs, r_rc, r_accx, r_accy;
    logic [60:0] r_ur, r_phi;
    logic [31:0] r_us;
    logic        r_mneg;
    logic [63:0] r_plo;

    logic r_out_valid;
    logic signed [WORD_BITS-1:0] r_ox, r_oy;
    logic [ANG_BITS-1:0] r_oh;

    logic [AXLE_BITS-1:0] w_len;
    logic [32:0] w_ma;
    logic [31:0] w_mb;
    logic [64:0] w_prod;
    logic signed [SUM_BITS-1:0] w_sum, w_diff;
    logic [63:0] w_rem2;
    logic        w_ge;
    logic [ANG_BITS-1:0] w_ang, w_q, w_tn;
    logic signed [CV_BITS-1:0] w_z0, w_zf, w_ysh, w_xsh, w_at;
    logic w_fl;
    logic signed [63:0] w_a, w_ac, w_sres, w_nx, w_ny, w_rr;
    logic signed [CV_BITS-1:0] w_b;
    logic [CV_BITS-1:0] w_bm;
    logic [63:0] w_res, w_resc, w_ua, w_rm;
    logic [31:0] w_d;

    assign w_len = (r_axle == '0) ? AXLE_BITS'(1) : r_axle;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_NUM:   begin w_ma = r_abs_diff;                  w_mb = 32'(r_dt); end
            OP_DEN:   begin w_ma = TWOPI_Q29;                   w_mb = 32'(w_len); end
            OP_RNUM:  begin w_ma = r_abs_sum;                   w_mb = 32'(w_len); end
            OP_DIST:  begin w_ma = {1'b0, r_abs_sum[32:1]};     w_mb = 32'(r_dt); end
            OP_MQ_LO: begin w_ma = {1'b0, r_ur[31:0]};          w_mb = r_us; end
            OP_MQ_HI: begin w_ma = {4'b0, r_ur[60:32]};         w_mb = r_us; end
            default:  begin w_ma = '0;                          w_mb = '0; end
        endcase
        w_prod = 65'(w_ma) * 65'(w_mb);
    end

    always_comb begin
        w_sum  = SUM_BITS'(i_left_speed) + SUM_BITS'(i_right_speed);
        w_diff = SUM_BITS'(i_right_speed) - SUM_BITS'(i_left_speed);
        w_rem2 = {r_rem[62:0], r_dvd[DVD_BITS-1]};
        w_ge   = (w_rem2 >= r_dvs);
        w_q    = r_quo[ANG_BITS-1:0];
        w_tn   = r_diff[SUM_BITS-1] ? (ANG_BITS'(0) - w_q) : w_q;
        w_rm   = ($signed(r_quo) > WIDE_LIM || r_quo[63]) ? 64'(WIDE_LIM) : r_quo;
        w_rr   = (r_sum[SUM_BITS-1] != r_diff[SUM_BITS-1]) ? -$signed(w_rm) : $signed(w_rm);
        w_d    = w_prod[FRAC_BITS +: 32];
    end

    // CORDIC load angle, quarter-turn fold and one rotation step
    always_comb begin
        w_ang = (i_cmd.op == OP_RSAVE) ? r_turn : r_hd;
        w_z0  = $signed({{(CV_BITS-ANG_BITS){w_ang[ANG_BITS-1]}}, w_ang});
        w_fl  = 1'b0;
        w_zf  = w_z0;
        if (w_z0 > QUARTER) begin
            w_zf = w_z0 - HALF;
            w_fl = 1'b1;
        end else if (w_z0 < -QUARTER) begin
            w_zf = w_z0 + HALF;
            w_fl = 1'b1;
        end
        w_ysh = r_cy >>> r_ccnt[4:0];
        w_xsh = r_cx >>> r_ccnt[4:0];
        w_at  = $signed({2'b00, ATAN_BAM[r_ccnt[4:0]]});
    end

    // operand select for the Q30 product, its final combine and the saturated next pose
    always_comb begin
        case (i_cmd.asel)
            A_DIST:  w_a = r_dist;
            A_R:     w_a = r_r;
            A_RS:    w_a = r_rs;
            default: w_a = r_rc;
        endcase
        case (i_cmd.bsel)
            B_CH:    w_b = r_ch;
            B_SH:    w_b = r_sh;
            B_CA:    w_b = r_ca;
            default: w_b = r_sa;
        endcase
        if (w_a > WIDE_LIM) begin
            w_ac = WIDE_LIM;
        end else if (w_a < -WIDE_LIM) begin
            w_ac = -WIDE_LIM;
        end else begin
            w_ac = w_a;
        end
        w_ua   = (w_ac < 0) ? 64'(-w_ac) : 64'(w_ac);
        w_bm   = (w_b < 0) ? CV_BITS'(-w_b) : CV_BITS'(w_b);
        w_res  = {1'b0, r_phi, 2'b00} + {30'b0, r_plo[63:30]};
        w_resc = (w_res > 64'(WIDE_LIM)) ? 64'(WIDE_LIM) : w_res;
        w_sres = r_mneg ? -$signed(w_resc) : $signed(w_resc);
        w_nx   = 64'(r_px) + r_accx;
        w_ny   = 64'(r_py) + r_accy;
        if (w_nx > POS_MAX) w_nx = POS_MAX;
        else if (w_nx < POS_MIN) w_nx = POS_MIN;
        if (w_ny > POS_MAX) w_ny = POS_MAX;
        else if (w_ny < POS_MIN) w_ny = POS_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axle      <= AXLE_RESET;
            r_dt        <= DT_RESET;
            r_px        <= '0;
            r_py        <= '0;
            r_hd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AXLE: r_axle <= i_cfg_data[AXLE_BITS-1:0];
                    CFG_DT:   r_dt   <= i_cfg_data[DT_BITS-1:0];
                    default:  r_dt   <= r_dt;
                endcase
            end
            if (i_cmd.op == OP_UPDATE) begin
                r_px        <= w_nx[WORD_BITS-1:0];
                r_py        <= w_ny[WORD_BITS-1:0];
                r_hd        <= r_hd + r_turn;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sum      <= w_sum;
                r_diff     <= w_diff;
                r_abs_sum  <= w_sum[SUM_BITS-1] ? SUM_BITS'(-w_sum) : w_sum;
                r_abs_diff <= w_diff[SUM_BITS-1] ? SUM_BITS'(-w_diff) : w_diff;
                r_accx     <= '0;
                r_accy     <= '0;
                r_cx       <= GAIN_Q30;
                r_cy       <= '0;
                r_cz       <= w_zf;
                r_flip     <= w_fl;
                r_ccnt     <= '0;
            end
            OP_CORD_STEP: begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - w_ysh;
                    r_cy <= r_cy + w_xsh;
                    r_cz <= r_cz - w_at;
                end else begin
                    r_cx <= r_cx + w_ysh;
                    r_cy <= r_cy - w_xsh;
                    r_cz <= r_cz + w_at;
                end
                r_ccnt <= r_ccnt + CCNT_BITS'(1);
            end
            OP_CORD_SAVE_H: begin
                r_ch <= r_flip ? -r_cx : r_cx;
                r_sh <= r_flip ? -r_cy : r_cy;
            end
            OP_CORD_SAVE_T: begin
                r_ca <= r_flip ? -r_cx : r_cx;
                r_sa <= r_flip ? -r_cy : r_cy;
            end
            OP_NUM: begin
                r_num <= w_prod[NUM_BITS-1:0];
            end
            OP_DEN: begin
                r_dvd  <= {r_num, {TURN_SHIFT{1'b0}}};
                r_dvs  <= w_prod[63:0];
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= DCNT_BITS'(DVD_BITS);
            end
            OP_RNUM: begin
                r_dvd  <= {w_prod[63:0], {(DVD_BITS-64){1'b0}}};
                r_dvs  <= {30'b0, r_abs_diff, 1'b0};
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= DCNT_BITS'(64);
            end
            OP_DIV_STEP: begin
                r_dvd  <= {r_dvd[DVD_BITS-2:0], 1'b0};
                r_rem  <= w_ge ? (w_rem2 - r_dvs) : w_rem2;
                r_quo  <= {r_quo[62:0], w_ge};
                r_dcnt <= r_dcnt - DCNT_BITS'(1);
            end
            OP_TURN: begin
                r_turn <= w_tn;
            end
            OP_DIST: begin
                r_dist <= r_sum[SUM_BITS-1] ? -$signed({32'b0, w_d}) : $signed({32'b0, w_d});
            end
            OP_RSAVE: begin
                r_r    <= w_rr;
                r_cx   <= GAIN_Q30;
                r_cy   <= '0;
                r_cz   <= w_zf;
                r_flip <= w_fl;
                r_ccnt <= '0;
            end
            OP_MQ_PREP: begin
                r_ur   <= w_ua[60:0];
                r_us   <= (w_bm > CV_BITS'(34'd2147483648)) ? 32'h8000_0000 : w_bm[31:0];
                r_mneg <= (w_a < 0) != (w_b < 0);
            end
            OP_MQ_LO: begin
                r_plo <= w_prod[63:0];
            end
            OP_MQ_HI: begin
                r_phi <= w_prod[60:0];
            end
            OP_MQ_FIN: begin
                case (i_cmd.dst)
                    D_RS: begin
                        r_rs   <= w_sres;
                        r_accx <= -w_sres;
                    end
                    D_RC: begin
                        r_rc   <= w_sres;
                        r_accy <= w_sres;
                    end
                    D_XADD:  r_accx <= r_accx + w_sres;
                    D_YADD:  r_accy <= r_accy + w_sres;
                    default: r_accy <= r_accy - w_sres;
                endcase
            end
            OP_UPDATE: begin
                r_ox <= w_nx[WORD_BITS-1:0];
                r_oy <= w_ny[WORD_BITS-1:0];
                r_oh <= r_hd + r_turn;
            end
            default: begin
                r_num <= r_num;
            end
        endcase
    end

    assign o_stat.cord_done = (r_ccnt == CCNT_BITS'(CORDIC_STEPS));
    assign o_stat.div_done  = (r_dcnt == '0);
    assign o_stat.turn_zero = (r_turn == '0);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_pose_x    = r_ox;
    assign o_pose_y    = r_oy;
    assign o_heading   = r_oh;

endmodule
`default_nettype wire

// ===== sim/tb_diff_drive_pose_step_unit.sv =====
// Testbench for diff_drive_pose_step_unit: drives wheel-speed words, predicts each pose
// word with an in-bench fixed-point integrator and checks every output word in order.
// Depends on ddp_pkg, ddp_if and the RTL of the unit.
`default_nettype none

class pose_scoreboard;
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        hd;
    } pose_t;

    localparam longint WLIM = longint'(1) << 60;

    longint unsigned axle;
    longint unsigned dt;
    longint          px;
    longint          py;
    logic [31:0]     hd;
    pose_t           pending[$];
    int              mismatches;

    function new();
        axle = 65536;
        dt = 655;
        px = 0;
        py = 0;
        hd = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [30:0] data);
        if (idx == ddp_pkg::CFG_AXLE) axle = data;
        else if (idx == ddp_pkg::CFG_DT) dt = data[16:0];
    endfunction

    function longint unsigned magn(longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function longint clamp_w(longint v);
        if (v > WLIM) return WLIM;
        if (v < -WLIM) return -WLIM;
        return v;
    endfunction

    function longint scale_q30(longint r, longint s);
        longint unsigned ur, us, hi, lo, res;
        ur = magn(clamp_w(r));
        us = magn(s);
        if (us > (64'd1 << 31)) us = 64'd1 << 31;
        hi = (ur >> 32) * us;
        lo = (ur & 64'hFFFF_FFFF) * us;
        res = (hi << 2) + (lo >> 30);
        if (res > WLIM) res = WLIM;
        return ((r < 0) != (s < 0)) ? -longint'(res) : longint'(res);
    endfunction

    function void rotate(logic [31:0] ang, output longint c, output longint s);
        longint z, x, y, t;
        bit flip;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > (longint'(1) << 30)) begin
            z -= longint'(1) << 31;
            flip = 1;
        end else if (z < -(longint'(1) << 30)) begin
            z += longint'(1) << 31;
            flip = 1;
        end
        for (int i = 0; i < ddp_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ddp_pkg::ATAN_BAM[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ddp_pkg::ATAN_BAM[i]);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function void note_tick(logic signed [31:0] l, logic signed [31:0] r);
        longint vl, vr, sum, diff, ch, sh, dx, dy, v, rr, rs, rc, ca, sa;
        longint unsigned len, num, den, rem, d, rm;
        logic [31:0] q, turn;
        pose_t p;
        vl = l;
        vr = r;
        sum = vl + vr;
        diff = vr - vl;
        len = axle ? axle : 1;
        turn = 0;
        rotate(hd, ch, sh);
        if (diff != 0) begin
            num = magn(diff) * dt;
            den = 64'd3373259426 * len;
            rem = num % den;
            q = 32'(num / den);
            for (int k = 0; k < ddp_pkg::TURN_SHIFT; k++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem -= den;
                    q[0] = 1'b1;
                end
            end
            turn = diff < 0 ? 32'd0 - q : q;
        end
        if (turn == 0) begin
            v = sum / 2;
            d = (magn(v) * dt) >> ddp_pkg::FRAC_BITS;
            dx = scale_q30(v < 0 ? -longint'(d) : longint'(d), ch);
            dy = scale_q30(v < 0 ? -longint'(d) : longint'(d), sh);
        end else begin
            rm = (len * magn(sum)) / (2 * magn(diff));
            if (rm > WLIM) rm = WLIM;
            rr = ((sum < 0) != (diff < 0)) ? -longint'(rm) : longint'(rm);
            rs = scale_q30(rr, sh);
            rc = scale_q30(rr, ch);
            rotate(turn, ca, sa);
            dx = scale_q30(rs, ca) - rs + scale_q30(rc, sa);
            dy = scale_q30(rs, sa) - scale_q30(rc, ca) + rc;
        end
        px = sat32(px + dx);
        py = sat32(py + dy);
        hd = hd + turn;
        p.px = px[31:0];
        p.py = py[31:0];
        p.hd = hd;
        pending.push_back(p);
    endfunction

    function void check_pose(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] h);
        pose_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose word x=%0d y=%0d h=%0h", x, y, h);
            return;
        end
        e = pending.pop_front();
        if (e.px !== x || e.py !== y || e.hd !== h) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pose mismatch: exp x=%0d y=%0d h=%0h got x=%0d y=%0d h=%0h",
                         e.px, e.py, e.hd, x, y, h);
        end
    endfunction
endclass

module tb_diff_drive_pose_step_unit;
    import ddp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;
    int cycles = 0;
    int out_hold = 0;
    bit no_idle = 0;
    pose_scoreboard sb;

    ddp_in_if in_ch();
    ddp_out_if out_ch();

    diff_drive_pose_step_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.left_speed = '0;
        in_ch.right_speed = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[diff_drive_pose_step_unit] ERROR");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_pose(out_ch.pose_x, out_ch.pose_y, out_ch.heading);
            out_hold = no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready = 1'b0;
        else if (out_hold > 0) begin
            out_ch.ready = 1'b0;
            out_hold--;
        end else out_ch.ready = 1'b1;
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_tick(logic signed [31:0] l, logic signed [31:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.left_speed = l;
        in_ch.right_speed = r;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_tick(l, r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_ticks(int n);
        logic signed [31:0] l, r;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: begin
                    l = $urandom;
                    r = $urandom;
                end
                1: begin
                    l = $urandom;
                    r = l;
                end
                2: begin
                    l = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                    r = l + $signed($urandom_range(0, 6)) - 3;
                end
                default: begin
                    l = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                    r = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                end
            endcase
            send_tick(l, r);
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, straight and curved, tiny turns, wrap and saturation
        send_tick(0, 0);
        send_tick(32'sd65536, 32'sd65536);
        send_tick(32'sd65536, -32'sd65536);
        send_tick(-32'sd65536, 32'sd65536);
        send_tick(32'sd100, 32'sd101);
        send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_tick(32'sh8000_0000, 32'sh8000_0000);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(32'sh7FFF_FFFF, 0);
        send_tick(-1, 1);
        drain();
        write_reg(CFG_AXLE, 31'd1);
        write_reg(CFG_DT, 31'd65536);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(32'sd5, -32'sd7);
        send_tick(32'sh8000_0000, 32'sh8000_0000);
        send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_tick(32'sd3, 32'sd4);
        drain();
        write_reg(CFG_AXLE, 31'd0);
        write_reg(CFG_DT, 31'd0);
        send_tick(32'sd65536, 32'sd131072);
        send_tick(32'sd1000, 32'sd1000);
        drain();
        write_reg(CFG_AXLE, 31'h7FFF_FFFF);
        write_reg(CFG_DT, 31'h1_FFFF);
        send_tick(32'sd1, -32'sd1);
        send_tick(32'sh7FFF_FFFF, 32'sh8000_0000);
        drain();

        write_reg(CFG_AXLE, 31'd65536);
        write_reg(CFG_DT, 31'd655);
        random_ticks(160);
        drain();
        write_reg(CFG_AXLE, 31'd1);
        write_reg(CFG_DT, 31'd65536);
        random_ticks(160);
        drain();
        no_idle = 1;
        write_reg(CFG_AXLE, 31'h7FFF_FFFF);
        write_reg(CFG_DT, 31'd1);
        random_ticks(160);
        drain();
        no_idle = 0;
        for (int ph = 0; ph < 2; ph++) begin
            write_reg(CFG_AXLE, CFG_BITS'($urandom_range(0, 32'h7FFF_FFFF)));
            write_reg(CFG_DT, CFG_BITS'($urandom_range(0, 65536)));
            random_ticks(160);
            drain();
        end

        repeat (300) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[diff_drive_pose_step_unit] OK");
        end else begin
            $display("[diff_drive_pose_step_unit] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
